### rtl/core/wgtg_pkg.sv
// package for the waypoint go-to-goal controller
// constants, register indexes, state codes and the arctangent table; no dependencies
`default_nettype none
package wgtg_pkg;
  localparam int MaxWaypoints = 64;
  localparam int AddrW = $clog2(MaxWaypoints);
  localparam int CountW = $clog2(MaxWaypoints + 1);
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int CW = 27;
  localparam int ZW = 28;
  localparam logic signed [ZW-1:0] PiQ24 = 28'sd52707179;

  localparam logic [1:0] RegTurnGain = 2'd0;
  localparam logic [1:0] RegMoveGain = 2'd1;
  localparam logic [1:0] RegDistTol = 2'd2;
  localparam logic [1:0] RegAngleTol = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_CORD  = 7'b0001000,
    S_ERR   = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0: atan_q24 = 28'sd13176795;
      5'd1: atan_q24 = 28'sd7778716;
      5'd2: atan_q24 = 28'sd4110060;
      5'd3: atan_q24 = 28'sd2086331;
      5'd4: atan_q24 = 28'sd1047214;
      5'd5: atan_q24 = 28'sd524117;
      5'd6: atan_q24 = 28'sd262123;
      5'd7: atan_q24 = 28'sd131069;
      default: atan_q24 = ZW'(28'sd65536 >>> (i - 5'd8));
    endcase
  endfunction
endpackage
`default_nettype wire

### rtl/core/wgtg_sqrt.sv
// bit-serial floor square root, two radicand bits per cycle
// no dependencies; widths fixed for a 34-bit radicand
`default_nettype none
module wgtg_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [33:0] value,
  output logic             done,
  output logic [16:0]      root
);
  logic [33:0] v_r, v_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [18:0] trial;
  logic [18:0] shifted;

  always_comb begin
    shifted = {rem_r[16:0], v_r[33:32]};
    trial = {q_r, 2'b01};
    v_nxt = v_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done = busy_r && (cnt_r == 5'd0);
    if (start) begin
      v_nxt = value; rem_nxt = '0; q_nxt = '0; cnt_nxt = 5'd17; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end else begin
        v_nxt = {v_r[31:0], 2'b00};
        if (shifted >= trial) begin
          rem_nxt = shifted - trial; q_nxt = {q_r[15:0], 1'b1};
        end else begin
          rem_nxt = shifted; q_nxt = {q_r[15:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end
  assign root = q_r;

  always_ff @(posedge clk) begin
    v_r <= v_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/core/waypoint_go_to_goal_controller_top.sv
// top level of the waypoint go-to-goal controller
// depends on wgtg_pkg and wgtg_sqrt
`default_nettype none
// A load transfer gives no result; loads beyond 64 waypoints are dropped. A
// pose transfer reads the current waypoint, runs 16 CORDIC vectoring
// iterations one per cycle (after a pre-rotation by pi when the offset points
// to negative x) and, when the heading is within tolerance, a square root for
// the distance. The result register is loaded from the error state when
// turning or with no waypoint left, and from the square-root state when
// driving or reaching. One item is in work at a time: the next is taken the
// cycle after the result has been transferred.
// Configuration writes take effect at once and belong where nothing is in work.
// The waypoint store needs no clearing after reset.
module waypoint_go_to_goal_controller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command, pose_x, pose_y, pose_heading, waypoint_x, waypoint_y
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // turn_rate, forward_speed, target_index, reached, finished
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int CW = wgtg_pkg::CW;
  localparam int ZW = wgtg_pkg::ZW;
  wgtg_pkg::state_t st_r;
  logic [7:0] tg_r, mg_r;
  logic [14:0] dt_r, at_r;
  logic [31:0] mem [wgtg_pkg::MaxWaypoints];
  logic [31:0] rd_r;
  logic [wgtg_pkg::CountW-1:0] total_r, tgt_r;
  logic signed [15:0] px_r, py_r;
  logic signed [14:0] hd_r;
  logic signed [16:0] dx_r, dy_r;
  logic signed [16:0] dx_w, dy_w;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [wgtg_pkg::StepW-1:0] i_r;
  logic signed [17:0] err_r;
  logic obusy_r;
  logic [39:0] od_r;
  logic sq_start, sq_done;
  logic [16:0] root;
  logic [33:0] sumsq_r;
  logic signed [CW-1:0] ys, xs;
  logic [17:0] mag;
  logic signed [26:0] tprod;
  logic signed [17:0] tsh;
  logic [25:0] sprod;
  logic [17:0] ssh;
  logic has_tgt;
  logic in_fire;

  assign in_tready = (st_r == wgtg_pkg::S_IDLE) && !obusy_r;
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = obusy_r;
  assign out_tdata = od_r;
  assign has_tgt = tgt_r < total_r;
  assign dx_w = 17'($signed(rd_r[15:0])) - 17'(px_r);
  assign dy_w = 17'($signed(rd_r[31:16])) - 17'(py_r);
  assign ys = y_r >>> i_r;
  assign xs = x_r >>> i_r;
  assign mag = err_r[17] ? 18'(-err_r) : 18'(err_r);
  assign tprod = 27'($signed({1'b0, tg_r})) * 27'(err_r) + 27'sd128;
  assign tsh = 18'(tprod >>> 8);
  assign sprod = 26'(mg_r) * 26'(root) + 26'd128;
  assign ssh = sprod[25:8];
  assign sq_start = (st_r == wgtg_pkg::S_ERR) && has_tgt && !(mag > {3'b0, at_r});

  wgtg_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .value(sumsq_r),
    .done(sq_done), .root(root));

  always_ff @(posedge clk) begin
    if (in_fire && !in_tdata[0] && total_r < wgtg_pkg::CountW'(wgtg_pkg::MaxWaypoints))
      mem[total_r[wgtg_pkg::AddrW-1:0]] <= {in_tdata[79:64], in_tdata[63:48]};
    rd_r <= mem[tgt_r[wgtg_pkg::AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wgtg_pkg::S_IDLE; obusy_r <= 1'b0;
      tg_r <= 8'd179; mg_r <= 8'd205; dt_r <= 15'd102; at_r <= 15'd492;
      total_r <= '0; tgt_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          wgtg_pkg::RegTurnGain: tg_r <= cfg_data[7:0];
          wgtg_pkg::RegMoveGain: mg_r <= cfg_data[7:0];
          wgtg_pkg::RegDistTol:  dt_r <= cfg_data;
          wgtg_pkg::RegAngleTol: at_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) obusy_r <= 1'b0;
      unique case (st_r)
        wgtg_pkg::S_IDLE: if (in_fire) begin
          px_r <= in_tdata[16:1]; py_r <= in_tdata[32:17]; hd_r <= in_tdata[47:33];
          if (!in_tdata[0]) begin
            if (total_r < wgtg_pkg::CountW'(wgtg_pkg::MaxWaypoints))
              total_r <= total_r + 1'b1;
          end else st_r <= wgtg_pkg::S_READ;
        end
        wgtg_pkg::S_READ: st_r <= wgtg_pkg::S_PREP;
        wgtg_pkg::S_PREP: begin
          dx_r <= dx_w;
          dy_r <= dy_w;
          sumsq_r <= 34'(34'(dx_w) * 34'(dx_w));
          x_r <= CW'(dx_w) <<< 8;
          y_r <= CW'(dy_w) <<< 8;
          z_r <= '0; i_r <= '0;
          st_r <= wgtg_pkg::S_CORD;
        end
        wgtg_pkg::S_CORD: begin
          if (i_r == '0 && x_r < 0) begin
            x_r <= -x_r; y_r <= -y_r;
            z_r <= (y_r >= 0) ? wgtg_pkg::PiQ24 : -wgtg_pkg::PiQ24;
            i_r <= i_r;
          end else begin
            if (i_r == '0) sumsq_r <= 34'(sumsq_r + 34'(34'(dy_r) * 34'(dy_r)));
            if (y_r > 0) begin
              x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + wgtg_pkg::atan_q24(5'(i_r));
            end else begin
              x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - wgtg_pkg::atan_q24(5'(i_r));
            end
            i_r <= i_r + 1'b1;
            if (i_r == wgtg_pkg::StepW'(wgtg_pkg::CordicSteps - 1)) begin
              st_r <= wgtg_pkg::S_ERR;
            end
          end
        end
        wgtg_pkg::S_ERR: begin
          if (!has_tgt) begin
            od_r <= {1'b1, 1'b0, 7'(tgt_r), 15'd0, 16'd0};
            obusy_r <= 1'b1; st_r <= wgtg_pkg::S_IDLE;
          end else if (mag > {3'b0, at_r}) begin
            od_r <= {1'b0, 1'b0, 7'(tgt_r), 15'd0,
              (tsh > 18'sd32767) ? 16'h7fff : (tsh < -18'sd32768) ? 16'h8000 : tsh[15:0]};
            obusy_r <= 1'b1; st_r <= wgtg_pkg::S_IDLE;
          end else st_r <= wgtg_pkg::S_SQRT;
        end
        wgtg_pkg::S_SQRT: if (sq_done) begin
          if (root > {2'b0, dt_r}) begin
            od_r <= {1'b0, 1'b0, 7'(tgt_r), (ssh > 18'd32767) ? 15'h7fff : ssh[14:0], 16'd0};
          end else begin
            od_r <= {(tgt_r + 1'b1) >= total_r, 1'b1, 7'(tgt_r + 1'b1), 15'd0, 16'd0};
            tgt_r <= tgt_r + 1'b1;
          end
          obusy_r <= 1'b1; st_r <= wgtg_pkg::S_IDLE;
        end
        wgtg_pkg::S_OUT: st_r <= wgtg_pkg::S_IDLE;
        default: st_r <= wgtg_pkg::S_IDLE;
      endcase
      if (st_r == wgtg_pkg::S_CORD && i_r == wgtg_pkg::StepW'(wgtg_pkg::CordicSteps - 1)) begin
        // zero offset gives a bearing of zero
        if (dx_r == '0 && dy_r == '0)
          err_r <= -18'(hd_r);
        else
          err_r <= 18'(ZW'(((y_r > 0) ? z_r + wgtg_pkg::atan_q24(5'(i_r))
                   : z_r - wgtg_pkg::atan_q24(5'(i_r))) + ZW'(2048)) >>> 12) - 18'(hd_r);
      end
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with result pending");
  a_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    tgt_r <= total_r) else $error("target beyond total");
`endif
endmodule
`default_nettype wire

### tb/waypoint_go_to_goal_controller_top_tb.sv
// testbench for the waypoint go-to-goal controller top level
// checks every pose result against an in-bench predictor; depends on wgtg_pkg and the rtl
`timescale 1ns / 100ps
module waypoint_go_to_goal_controller_top_tb;

  typedef struct packed {
    logic        finished;
    logic        reached;
    logic [6:0]  target_index;
    logic [14:0] forward_speed;
    logic signed [15:0] turn_rate;
  } motion_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  waypoint_go_to_goal_controller_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] path_x [wgtg_pkg::MaxWaypoints];
  logic signed [15:0] path_y [wgtg_pkg::MaxWaypoints];
  int unsigned path_len = 0;
  int unsigned aim_idx = 0;
  logic [7:0]  k_turn = 8'd179;
  logic [7:0]  k_move = 8'd205;
  logic [14:0] tol_dist = 15'd102;
  logic [14:0] tol_angle = 15'd492;

  motion_cmd_t pending_cmds[$];
  bit  idling = 1'b1;
  bit  failed = 1'b0;
  int  sent_count = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  function automatic longint arctan_step(int i);
    case (i)
      0: arctan_step = 13176795;
      1: arctan_step = 7778716;
      2: arctan_step = 4110060;
      3: arctan_step = 2086331;
      4: arctan_step = 1047214;
      5: arctan_step = 524117;
      6: arctan_step = 262123;
      7: arctan_step = 131069;
      default: arctan_step = longint'(65536) >>> (i - 8);
    endcase
  endfunction

  function automatic longint bearing_q12(longint dx, longint dy);
    longint x, y, z, nx;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 52707179 : -52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < wgtg_pkg::CordicSteps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end
      x = nx;
    end
    return (z + 2048) >>> 12;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // next pose result from the predictor, or none for a waypoint load
  task automatic predict_transfer(logic [79:0] d);
    motion_cmd_t m;
    longint dx, dy, err, mag, span, t;
    m = '0;
    if (d[0] == 1'b0) begin
      if (path_len < wgtg_pkg::MaxWaypoints) begin
        path_x[6'(path_len)] = d[63:48];
        path_y[6'(path_len)] = d[79:64];
        path_len++;
      end
      return;
    end
    if (aim_idx < path_len) begin
      dx = longint'(path_x[6'(aim_idx)]) - longint'($signed(d[16:1]));
      dy = longint'(path_y[6'(aim_idx)]) - longint'($signed(d[32:17]));
      err = bearing_q12(dx, dy) - longint'($signed(d[47:33]));
      mag = err < 0 ? -err : err;
      if (mag > longint'(tol_angle)) begin
        t = (longint'(k_turn) * err + 128) >>> 8;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        m.turn_rate = t[15:0];
      end else begin
        span = floor_sqrt(dx * dx + dy * dy);
        if (span > longint'(tol_dist)) begin
          t = (longint'(k_move) * span + 128) >>> 8;
          if (t > 32767) t = 32767;
          m.forward_speed = t[14:0];
        end else begin
          aim_idx++;
          m.reached = 1'b1;
        end
      end
    end
    m.target_index = aim_idx[6:0];
    m.finished = aim_idx >= path_len;
    pending_cmds.push_back(m);
  endtask

  // heading close to the bearing of the current waypoint
  function automatic logic signed [14:0] aimed_heading(logic signed [15:0] px,
                                                       logic signed [15:0] py, int noise);
    longint h;
    h = 0;
    if (aim_idx < path_len)
      h = bearing_q12(longint'(path_x[6'(aim_idx)]) - px,
                      longint'(path_y[6'(aim_idx)]) - py);
    h += longint'($urandom_range(2 * noise)) - longint'(noise);
    if (h > 12868) h = 12868;
    if (h < -12868) h = -12868;
    return h[14:0];
  endfunction

  task automatic send_item(logic cmd, logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [14:0] hd, logic signed [15:0] wx,
                           logic signed [15:0] wy);
    if (idling && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {wy, wx, hd, py, px, cmd};
    do @(posedge clk); while (!in_tready);
    predict_transfer({wy, wx, hd, py, px, cmd});
    sent_count++;
  endtask

  task automatic send_load(logic signed [15:0] wx, logic signed [15:0] wy);
    send_item(1'b0, 16'($urandom), 16'($urandom), 15'($urandom_range(25736) - 12868),
              wx, wy);
  endtask

  task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [14:0] hd);
    send_item(1'b1, px, py, hd, 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wgtg_pkg::RegTurnGain: k_turn = val[7:0];
      wgtg_pkg::RegMoveGain: k_move = val[7:0];
      wgtg_pkg::RegDistTol:  tol_dist = val;
      wgtg_pkg::RegAngleTol: tol_angle = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [7:0] tg, logic [7:0] mg, logic [14:0] dt, logic [14:0] at);
    write_reg(wgtg_pkg::RegTurnGain, {7'd0, tg});
    write_reg(wgtg_pkg::RegMoveGain, {7'd0, mg});
    write_reg(wgtg_pkg::RegDistTol, dt);
    write_reg(wgtg_pkg::RegAngleTol, at);
  endtask

  task automatic test_empty_and_path();
    send_pose(16'sd0, 16'sd0, 15'sd0);
    send_load(16'sd0, 16'sd0);
    send_load(16'sd32767, -16'sd32768);
    send_pose(16'sd0, 16'sd0, 15'sd12868);
    send_pose(16'sd0, 16'sd0, 15'sd0);
    send_pose(-16'sd32768, 16'sd32767, 15'sd12868);
    send_pose(-16'sd32768, 16'sd32767, aimed_heading(-16'sd32768, 16'sd32767, 0));
    send_pose(16'sd32767, -16'sd32768, -15'sd12868);
    send_pose(16'sd32767, -16'sd32768, 15'sd0);
    send_pose(16'sd100, 16'sd100, 15'sd0);
    // resume after finishing, offsets with negative x on both sides of the axis
    send_load(-16'sd32768, 16'sd32767);
    send_load(16'sd0, -16'sd100);
    send_pose(16'sd0, 16'sd0, -15'sd12868);
    send_pose(16'sd0, 16'sd0, aimed_heading(16'sd0, 16'sd0, 0));
    send_pose(-16'sd32768, 16'sd32767, 15'sd0);
    send_pose(16'sd50, 16'sd0, -15'sd12868);
    send_pose(16'sd50, 16'sd0, aimed_heading(16'sd50, 16'sd0, 0));
    send_pose(16'sd0, -16'sd100, 15'sd0);
  endtask

  task automatic test_register_extremes();
    send_load(16'sd4000, -16'sd3000);
    write_all(8'd255, 8'd255, 15'd0, 15'd0);
    send_pose(16'sd0, 16'sd0, 15'sd12868);
    send_pose(16'sd0, 16'sd0, aimed_heading(16'sd0, 16'sd0, 0));
    write_all(8'd0, 8'd0, 15'd32767, 15'd32767);
    send_pose(16'sd0, 16'sd0, 15'sd12868);
    write_all(8'd179, 8'd205, 15'd102, 15'd492);
  endtask

  task automatic test_random_paths();
    logic signed [15:0] px, py;
    int n, tol, r;
    while (sent_count < 1850) begin
      if (sent_count > 1650) idling = 1'b0;
      if (idling && $urandom_range(2) == 0) begin
        r = $urandom_range(3);
        if (r == 0) write_all(8'd255, 8'd0, 15'd32767, 15'd0);
        else if (r == 1) write_all(8'd0, 8'd255, 15'd0, 15'd32767);
        else write_all(8'($urandom), 8'($urandom), 15'($urandom_range(600)),
                       15'($urandom_range(1500)));
      end
      n = $urandom_range(1, 3);
      repeat (n) send_load(16'($urandom), 16'($urandom));
      repeat ($urandom_range(5, 25)) begin
        r = $urandom_range(7);
        if (aim_idx < path_len && r < 4) begin
          tol = tol_dist > 15'd20000 ? 10000 : int'(tol_dist);
          px = 16'(path_x[6'(aim_idx)] + $urandom_range(tol) - tol / 2);
          py = 16'(path_y[6'(aim_idx)] + $urandom_range(tol) - tol / 2);
          send_pose(px, py, aimed_heading(px, py, r == 0 ? 600 : 100));
        end else if (r < 6) begin
          px = 16'($urandom);
          py = 16'($urandom);
          send_pose(px, py, aimed_heading(px, py, 300));
        end else if (r == 6) begin
          send_pose(16'($urandom), 16'($urandom), 15'($urandom_range(25736) - 12868));
        end else begin
          send_load(16'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    motion_cmd_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[39:0];
      if (pending_cmds.size() == 0) begin
        $error("unexpected result transfer %h", out_tdata);
        failed = 1'b1;
      end else begin
        want = pending_cmds.pop_front();
        if (got.turn_rate !== want.turn_rate) begin
          $error("turn_rate expected %0d actual %0d", want.turn_rate, got.turn_rate);
          failed = 1'b1;
        end
        if (got.forward_speed !== want.forward_speed) begin
          $error("forward_speed expected %0d actual %0d", want.forward_speed,
                 got.forward_speed);
          failed = 1'b1;
        end
        if (got.target_index !== want.target_index) begin
          $error("target_index expected %0d actual %0d", want.target_index,
                 got.target_index);
          failed = 1'b1;
        end
        if (got.reached !== want.reached) begin
          $error("reached expected %0d actual %0d", want.reached, got.reached);
          failed = 1'b1;
        end
        if (got.finished !== want.finished) begin
          $error("finished expected %0d actual %0d", want.finished, got.finished);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_path();
    test_register_extremes();
    test_random_paths();
    wait_drain();
    if (!failed && pending_cmds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
